### design/shrld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_pkg: shared types and constants of the LED PWM shift-register driver
// Input and result word layouts, the internal command word and fixed widths.
// ----------------------------------------------------------------------------
package shrld_pkg;

    // Fixed field widths
    localparam int LED_IDX_W  = 5;
    localparam int LEVEL_W    = 3;
    localparam int BYTE_W     = 8;
    localparam int REG_IDX_W  = 3;
    localparam int ROW_SEL_W  = 2;   // led_num[4:3]
    localparam int LANE_W     = 3;   // led_num[2:0]

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] CFG_IDX_ACTIVE_LOW = '0;

    // Input word
    typedef struct packed {
        logic                 action;
        logic [LED_IDX_W-1:0] led_num;
        logic [LEVEL_W-1:0]   brightness;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0]    shift_byte;
        logic [REG_IDX_W-1:0] register_index;
        logic                 last_of_frame;
    } out_word_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic                 is_tick;
        logic [ROW_SEL_W-1:0] row;
        logic [LANE_W-1:0]    lane;
        logic [LEVEL_W-1:0]   level;
    } cmd_t;

endpackage

### design/shift_register_led_pwm_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_led_pwm_driver_core: multi-level LED PWM driver top level
// Keeps one brightness level per LED on a chain of 8-bit shift registers and
// emits one output word per register on every PWM tick.
// ----------------------------------------------------------------------------
// A brightness write is executed in the back end and produces no word; a
// write to an LED past the chain is dropped at the input. A tick produces
// NUM_SHIFT_REGS words, register 0 first, at one word per cycle while the
// output is not stalled: the brightness store is read one row (one shift
// register) per cycle, and the tick passes through the command queue, then
// each row through the read stage and the output register. Bit k of a word
// is on while the PWM phase is below the LED's level and is inverted when
// active_low is set; the last word of a tick carries last_of_frame for the
// latch pulse. The phase wraps at LEVELS. A two-entry command queue buffers
// input words while the output is stalled. Register active_low sits at byte address 0.
// ----------------------------------------------------------------------------
module shift_register_led_pwm_driver_core #(
    parameter int NUM_SHIFT_REGS = 4,
    parameter int LEVELS         = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  shrld_pkg::in_word_t                 s_data,
    // output words
    output logic                                m_valid,
    input  logic                                m_ready,
    output shrld_pkg::out_word_t                m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [shrld_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [shrld_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [shrld_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import shrld_pkg::*;

    logic active_low_reg;
    logic cfg_hit;

    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == CFG_IDX_ACTIVE_LOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            active_low_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(APB_DATA_W-1){1'b0}}, active_low_reg} : '0;

    // Front: classify
    shrld_front #(
        .NUM_SHIFT_REGS(NUM_SHIFT_REGS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd)
    );

    // Command queue
    shrld_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Back: store and frame sequencer
    shrld_back #(
        .NUM_SHIFT_REGS(NUM_SHIFT_REGS),
        .LEVELS        (LEVELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_head),
        .q_pop      (q_pop),
        .active_low (active_low_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### design/shrld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_front: input classifier
// Accepts input words, drops writes past the chain and turns the rest into
// commands for the command queue.
// ----------------------------------------------------------------------------
module shrld_front #(
    parameter int NUM_SHIFT_REGS = 4
) (
    input  logic             s_valid,
    output logic             s_ready,
    input  shrld_pkg::in_word_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output shrld_pkg::cmd_t  q_cmd
);
    import shrld_pkg::*;

    localparam int CNT_W = LED_IDX_W + 2;
    localparam logic [CNT_W-1:0] LED_COUNT = CNT_W'(NUM_SHIFT_REGS * BYTE_W);

    logic is_tick;
    logic in_range;

    // Accept whenever the queue has room
    assign s_ready  = !q_full;

    // Classify
    assign is_tick  = (s_data.action == ACT_TICK);
    assign in_range = {2'b00, s_data.led_num} < LED_COUNT;
    assign q_push   = s_valid && s_ready && (is_tick || in_range);

    always_comb begin
        q_cmd.is_tick = is_tick;
        q_cmd.row     = s_data.led_num[LED_IDX_W-1 -: ROW_SEL_W];
        q_cmd.lane    = s_data.led_num[LANE_W-1:0];
        q_cmd.level   = s_data.brightness;
    end

endmodule

### design/shrld_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_cmd_fifo: command queue
// Short FIFO that decouples the classifier from the frame sequencer.
// ----------------------------------------------------------------------------
module shrld_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  shrld_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output shrld_pkg::cmd_t head_cmd
);
    import shrld_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;

    assign full       = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/shrld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_back: brightness store and frame sequencer
// Executes brightness writes and, on a tick, walks the shift registers one
// row per cycle when not stalled, comparing each LED level to the PWM phase.
// ----------------------------------------------------------------------------
module shrld_back #(
    parameter int NUM_SHIFT_REGS = 4,
    parameter int LEVELS         = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  shrld_pkg::cmd_t      q_cmd,
    output logic                 q_pop,
    input  logic                 active_low,
    output logic                 m_valid,
    input  logic                 m_ready,
    output shrld_pkg::out_word_t m_data
);
    import shrld_pkg::*;

    localparam int ROW_W = (NUM_SHIFT_REGS > 1) ? $clog2(NUM_SHIFT_REGS) : 1;
    localparam int PH_W  = $clog2(LEVELS);
    localparam int CMP_W = (PH_W > LEVEL_W) ? PH_W : LEVEL_W;
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(NUM_SHIFT_REGS - 1);
    localparam logic [PH_W-1:0]  LAST_PH   = PH_W'(LEVELS - 1);

    // Brightness store: one row of eight levels per shift register
    logic [BYTE_W-1:0][LEVEL_W-1:0] mem [NUM_SHIFT_REGS];
    logic [NUM_SHIFT_REGS-1:0][BYTE_W-1:0] vld_reg;

    logic [BYTE_W-1:0][LEVEL_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0]              rd_vld_reg;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [PH_W-1:0]  phase_reg;
    logic [PH_W-1:0]  phase_next;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_last_reg;

    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             out_free;
    logic             s1_adv;
    logic             s1_free;
    logic             do_write;
    logic             do_issue;
    logic             issue_last;
    logic [ROW_W-1:0] w_row;
    logic [BYTE_W-1:0] byte_bits;

    // Handshake between the read stage and the output register
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign s1_free    = !s1_valid_reg || out_free;

    // Command execution
    assign do_write   = q_valid && !q_cmd.is_tick;
    assign do_issue   = q_valid && q_cmd.is_tick && s1_free;
    assign issue_last = (row_reg == LAST_ROW);
    assign q_pop      = do_write || (do_issue && issue_last);
    assign w_row      = ROW_W'(q_cmd.row);

    assign row_next   = issue_last ? '0 : row_reg + 1'b1;
    assign phase_next = (phase_reg == LAST_PH) ? '0 : phase_reg + 1'b1;

    // Store write port and registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[w_row][q_cmd.lane] <= q_cmd.level;
        end
        if (do_issue) begin
            rd_data_reg <= mem[row_reg];
            rd_vld_reg  <= vld_reg[row_reg];
        end
    end

    // Written flags; an unwritten LED reads as off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (do_write) begin
            vld_reg[w_row][q_cmd.lane] <= 1'b1;
        end
    end

    // Row sequencer and read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (do_issue) begin
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_issue) begin
            s1_row_reg  <= row_reg;
            s1_last_reg <= issue_last;
        end
    end

    // PWM compare for the eight outputs of one register
    always_comb begin
        for (int k = 0; k < BYTE_W; k++) begin
            byte_bits[k] = rd_vld_reg[k] &&
                           (CMP_W'(phase_reg) < CMP_W'(rd_data_reg[k]));
        end
    end

    // Phase advances when the last word of a frame leaves the read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (s1_adv && s1_last_reg) begin
            phase_reg <= phase_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg.shift_byte     <= byte_bits ^ {BYTE_W{active_low}};
            m_data_reg.register_index <= REG_IDX_W'(s1_row_reg);
            m_data_reg.last_of_frame  <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/shrld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_checker: port-level checks of the LED PWM driver
// Watches the output channel for frame ordering and output stability.
// ----------------------------------------------------------------------------
module shrld_checker #(
    parameter int NUM_SHIFT_REGS = 4
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input shrld_pkg::out_word_t m_data
);
    import shrld_pkg::*;

    localparam logic [REG_IDX_W-1:0] LAST_IDX = REG_IDX_W'(NUM_SHIFT_REGS - 1);

    logic [REG_IDX_W-1:0] exp_idx_reg;

    // Expected register index of the next output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_idx_reg <= m_data.last_of_frame ? '0 : exp_idx_reg + 1'b1;
        end
    end

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // Words of a frame come in register order
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.register_index == exp_idx_reg)
        else $error("register index out of sequence");

    // Latch mark exactly on the last register
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_frame == (m_data.register_index == LAST_IDX)))
        else $error("last_of_frame misplaced");

    // No word right out of reset
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid right after reset");

endmodule

bind shift_register_led_pwm_driver_core shrld_checker #(
    .NUM_SHIFT_REGS(NUM_SHIFT_REGS)
) u_shrld_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### sim/shrld_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrld_frame_checker: frame predictor and word checker for the LED PWM driver
// Watches the input, output and configuration ports, keeps its own copy of the
// brightness store, PWM phase and polarity, predicts every frame byte of a
// tick and compares each output word in order with the oldest prediction.
// ----------------------------------------------------------------------------
module shrld_frame_checker #(
    parameter int NUM_SHIFT_REGS = 4,
    parameter int LEVELS         = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  shrld_pkg::in_word_t                 s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  shrld_pkg::out_word_t                m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [shrld_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [shrld_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                  mismatches,
    output int                                  bytes_owed
);
    import shrld_pkg::*;

    localparam int LED_COUNT = NUM_SHIFT_REGS * BYTE_W;

    // Shadow copy of the block state
    logic [LEVEL_W-1:0] led_level [LED_COUNT];
    int unsigned        pwm_step;
    logic               invert_out;

    // Frame bytes predicted but not yet seen on the output
    out_word_t          frame_q[$];

    // Build all bytes of one tick, then advance the phase
    task automatic render_frame();
        out_word_t         w;
        logic [BYTE_W-1:0] bits;
        for (int r = 0; r < NUM_SHIFT_REGS; r++) begin
            for (int k = 0; k < BYTE_W; k++) begin
                bits[k] = (pwm_step < led_level[r * BYTE_W + k]);
            end
            if (invert_out) begin
                bits = ~bits;
            end
            w.shift_byte     = bits;
            w.register_index = REG_IDX_W'(r);
            w.last_of_frame  = (r == NUM_SHIFT_REGS - 1);
            frame_q.push_back(w);
        end
        pwm_step = (pwm_step + 1 >= LEVELS) ? 0 : pwm_step + 1;
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        logic      bad;
        if (!aresetn) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                led_level[i] = '0;
            end
            pwm_step   = 0;
            invert_out = 1'b0;
            frame_q.delete();
            mismatches <= 0;
        end else begin
            // output word against oldest prediction
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: word 0x%0h arrived with no byte expected", $time, m_data);
                    mismatches <= mismatches + 1;
                end else begin
                    want = frame_q.pop_front();
                    bad  = 1'b0;
                    if (m_data.shift_byte !== want.shift_byte) begin
                        $display("%0t: shift_byte expected 0x%0h actual 0x%0h",
                                 $time, want.shift_byte, m_data.shift_byte);
                        bad = 1'b1;
                    end
                    if (m_data.register_index !== want.register_index) begin
                        $display("%0t: register_index expected %0d actual %0d",
                                 $time, want.register_index, m_data.register_index);
                        bad = 1'b1;
                    end
                    if (m_data.last_of_frame !== want.last_of_frame) begin
                        $display("%0t: last_of_frame expected %0b actual %0b",
                                 $time, want.last_of_frame, m_data.last_of_frame);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        mismatches <= mismatches + 1;
                    end
                end
            end

            // polarity register write
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_ADDR_W-1:2] == CFG_IDX_ACTIVE_LOW) begin
                    invert_out = pwdata[0];
                end
            end

            // accepted input word
            if (s_valid && s_ready) begin
                if (s_data.action == ACT_TICK) begin
                    render_frame();
                end else if (s_data.led_num < LED_COUNT) begin
                    led_level[s_data.led_num] = s_data.brightness;
                end
            end
        end
        bytes_owed <= frame_q.size();
    end

endmodule

### sim/tb_shift_register_led_pwm_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shift_register_led_pwm_driver_core: testbench of the LED PWM driver
// Drives brightness writes and PWM ticks with random gaps and output stalls,
// switches the output polarity between phases and leaves the checking to the
// frame checker beside the block and the assertions bound into it.
// ----------------------------------------------------------------------------
module tb_shift_register_led_pwm_driver_core;
    import shrld_pkg::*;

    localparam int NUM_SHIFT_REGS = 4;
    localparam int LEVELS         = 4;
    localparam int LED_COUNT      = NUM_SHIFT_REGS * BYTE_W;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_WORDS    = 60;

    localparam logic [APB_ADDR_W-3:0] CFG_IDX_UNUSED = 1'b1;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    bytes_owed;
    int                    cycles = 0;
    logic                  quiet  = 1'b0;   // no gaps, no stalls

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    shift_register_led_pwm_driver_core #(
        .NUM_SHIFT_REGS (NUM_SHIFT_REGS),
        .LEVELS         (LEVELS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    shrld_frame_checker #(
        .NUM_SHIFT_REGS (NUM_SHIFT_REGS),
        .LEVELS         (LEVELS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    // output stalls
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_shift_register_led_pwm_driver_core: errors");
            $finish;
        end
    end

    // one input word, with an occasional idle cycle in front
    task automatic send_word(input in_word_t w);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_tick();
        in_word_t w;
        w.action     = ACT_TICK;
        w.led_num    = LED_IDX_W'($urandom);
        w.brightness = LEVEL_W'($urandom);
        send_word(w);
    endtask

    task automatic send_level(input int idx, input int lvl);
        in_word_t w;
        w.action     = ACT_WRITE;
        w.led_num    = LED_IDX_W'(idx);
        w.brightness = LEVEL_W'(lvl);
        send_word(w);
    endtask

    // stop input, wait for all frame bytes and let the back end settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access; upper data bits are noise
    task automatic write_reg(input logic [APB_ADDR_W-3:0] idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_IDX_ACTIVE_LOW, 1'b0);

        // frame from reset state: all LEDs off
        send_tick();
        // extremes of index and level, level above full scale
        send_level(0, LEVELS);
        send_level(LED_COUNT - 1, 7);
        send_level(7, 1);
        send_level(8, 2);
        send_level(24, 3);
        send_level(16, LEVELS + 1);
        send_level(15, 0);
        repeat (LEVELS) send_tick();
        drain();

        // inverted outputs; a write to an unused register must not undo it
        write_reg(CFG_IDX_ACTIVE_LOW, 1'b1);
        write_reg(CFG_IDX_UNUSED, 1'b0);
        send_level(0, 0);
        send_level(LED_COUNT - 1, LEVELS);
        send_level(9, 6);
        repeat (LEVELS + 1) send_tick();
        drain();

        // random phases with alternating polarity, one without gaps or stalls
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_reg(CFG_IDX_ACTIVE_LOW, p[0]);
            quiet <= (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < 45) begin
                    send_tick();
                end else if ($urandom_range(0, 99) < 85) begin
                    send_level($urandom_range(0, LED_COUNT - 1), $urandom_range(0, LEVELS));
                end else begin
                    send_level($urandom_range(0, LED_COUNT - 1), $urandom_range(0, 7));
                end
            end
            drain();
            quiet <= 1'b0;
        end

        if (mismatches == 0) begin
            $display("tb_shift_register_led_pwm_driver_core: clean");
        end else begin
            $display("tb_shift_register_led_pwm_driver_core: errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/shrld_pkg.sv
design/shrld_front.sv
design/shrld_cmd_fifo.sv
design/shrld_back.sv
design/shift_register_led_pwm_driver_core.sv
design/shrld_checker.sv
sim/shrld_frame_checker.sv
sim/tb_shift_register_led_pwm_driver_core.sv
